// ===== hdl/mmdp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmdp_pkg
// shared types, constants and helpers of the matrix element dot product engine
// ---------------------------------------------------------------------------
package mmdp_pkg;

  // sizing
  localparam int MAX_DIM    = 16;
  localparam int ELEM_WIDTH = 16;
  localparam int DIM_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W      = $clog2(MAX_DIM + 1);
  localparam int IDX_W      = (DIM_W > 4) ? DIM_W : 4;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ACC_W      = 32;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd2;
  localparam logic [CFG_W-1:0]     CFG_RESET_DIM = 5'd4;

  // opcodes
  localparam int OPC_W = 2;
  localparam logic [OPC_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]               out_row;
    logic [3:0]               out_col;
    logic signed [ACC_W-1:0]  dot_value;
    logic                     index_error;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             capture;
    logic             rd_en;
    logic [DIM_W-1:0] rd_idx;
    logic             emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             ld_a_ok;
    logic             ld_b_ok;
    logic             cmp_err;
    logic [CNT_W-1:0] inner_cnt;
  } dp_sts_t;

  // index below both the register and the store size
  function automatic logic idx_ok(input logic [3:0] idx, input logic [CFG_W-1:0] lim);
    return (CFG_W'(idx) < lim) && (int'(idx) < MAX_DIM);
  endfunction

  // size register limited to the store size
  function automatic logic [CNT_W-1:0] clip_dim(input logic [CFG_W-1:0] v);
    return (int'(v) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(v);
  endfunction

  // row-major store address
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
  endfunction

  // input value reduced or extended to the element width
  function automatic logic [ELEM_WIDTH-1:0] to_elem(input logic signed [15:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    return w[ELEM_WIDTH-1:0];
  endfunction

endpackage

// ===== hdl/mmdp_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmdp_ram
// generic single write, single read memory with registered read data
// ---------------------------------------------------------------------------
module mmdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mmdp_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmdp_dp
// datapath: size registers, element stores, multiplier and accumulator
// ---------------------------------------------------------------------------
module mmdp_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mmdp_pkg::in_item_t                 in_item,
  input  logic                               cfg_we,
  input  logic [mmdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmdp_pkg::CFG_W-1:0]         cfg_data,
  input  mmdp_pkg::dp_cmd_t                  cmd,
  output mmdp_pkg::dp_sts_t                  sts,
  output logic                               out_strobe,
  output mmdp_pkg::out_item_t                out_item
);
  import mmdp_pkg::*;

  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] inner_r, inner_nxt;
  logic [CFG_W-1:0] cols_r, cols_nxt;

  logic [3:0]              row_r, col_r;
  logic                    err_r;
  logic                    rd_vld_r, prod_vld_r, out_strobe_r;
  logic [ELEM_WIDTH-1:0]   rd_a, rd_b;
  logic signed [ACC_W-1:0] a_ext, b_ext;
  logic signed [ACC_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  out_item_t               out_item_r;
  logic [ADDR_W-1:0]       waddr, raddr_a, raddr_b;

  // size register writes
  always_comb begin
    rows_nxt  = rows_r;
    inner_nxt = inner_r;
    cols_nxt  = cols_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ROWS:  rows_nxt  = cfg_data;
        CFG_INNER_LEN: inner_nxt = cfg_data;
        CFG_NUM_COLS:  cols_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= CFG_RESET_DIM;
      inner_r <= CFG_RESET_DIM;
      cols_r  <= CFG_RESET_DIM;
    end else begin
      rows_r  <= rows_nxt;
      inner_r <= inner_nxt;
      cols_r  <= cols_nxt;
    end
  end

  // range checks on the incoming beat
  always_comb begin
    sts.ld_a_ok   = idx_ok(in_item.row_index, rows_r) && idx_ok(in_item.col_index, inner_r);
    sts.ld_b_ok   = idx_ok(in_item.row_index, inner_r) && idx_ok(in_item.col_index, cols_r);
    sts.cmp_err   = !(idx_ok(in_item.row_index, rows_r) && idx_ok(in_item.col_index, cols_r));
    sts.inner_cnt = clip_dim(inner_r);
  end

  // store addresses
  assign waddr   = elem_addr(IDX_W'(in_item.row_index), IDX_W'(in_item.col_index));
  assign raddr_a = elem_addr(IDX_W'(row_r), IDX_W'(cmd.rd_idx));
  assign raddr_b = elem_addr(IDX_W'(cmd.rd_idx), IDX_W'(col_r));

  mmdp_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (waddr),
    .wdata (to_elem(in_item.elem_value)),
    .re    (cmd.rd_en),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  mmdp_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (waddr),
    .wdata (to_elem(in_item.elem_value)),
    .re    (cmd.rd_en),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_item.row_index;
      col_r <= in_item.col_index;
      err_r <= sts.cmp_err;
    end
  end

  // multiply, wrapped to the accumulator width
  always_comb begin
    a_ext    = ACC_W'($signed(rd_a));
    b_ext    = ACC_W'($signed(rd_b));
    prod_nxt = a_ext * b_ext;
  end

  // accumulate, cleared when a request is taken
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.capture) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // pipeline valid bits and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r     <= 1'b0;
      prod_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      rd_vld_r     <= cmd.rd_en;
      prod_vld_r   <= rd_vld_r;
      out_strobe_r <= cmd.emit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.out_row     <= row_r;
      out_item_r.out_col     <= col_r;
      out_item_r.dot_value   <= err_r ? '0 : acc_r;
      out_item_r.index_error <= err_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ===== hdl/mmdp_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmdp_ctrl
// controller: decodes beats and sequences the multiply-accumulate loop
// ---------------------------------------------------------------------------
module mmdp_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mmdp_pkg::OPC_W-1:0]   opcode,
  input  mmdp_pkg::dp_sts_t            sts,
  output mmdp_pkg::dp_cmd_t            cmd,
  output logic                         busy
);
  import mmdp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_DRAIN1 = 3'd2;
  localparam logic [2:0] S_DRAIN2 = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [DIM_W-1:0] idx_r, idx_nxt;
  logic             accept;
  logic             last_idx;

  assign accept   = start && (state_r == S_IDLE);
  assign last_idx = (CNT_W'(idx_r) + CNT_W'(1)) == sts.inner_cnt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    cmd.rd_idx  = idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_LOAD_A: cmd.wr_a = sts.ld_a_ok;
            OP_LOAD_B: cmd.wr_b = sts.ld_b_ok;
            OP_COMPUTE: begin
              cmd.capture = 1'b1;
              idx_nxt     = '0;
              if (sts.cmp_err || (sts.inner_cnt == '0)) begin
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd.rd_en = 1'b1;
        if (last_idx) begin
          state_nxt = S_DRAIN1;
        end else begin
          idx_nxt = idx_r + DIM_W'(1);
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_FINISH;
      S_FINISH: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // a compute request always occupies the engine on the next cycle
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (opcode == OP_COMPUTE)) |=> busy)
    else $error("compute request did not start the sequence");

  // loads and the unused opcode complete in the cycle they are taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (opcode != OP_COMPUTE)) |=> !busy)
    else $error("load or unused opcode left the engine busy");

  // the read index stays inside the inner length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (CNT_W'(idx_r) < sts.inner_cnt))
    else $error("read index beyond inner length");

  // one result per request: emit is followed by idle
  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (!cmd.emit && !busy))
    else $error("result emitted twice or engine stayed busy");

endmodule

// ===== hdl/matrix_element_dot_product.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_element_dot_product
// integer matrix multiply engine returning one result element per request
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  in_      | start & !busy        | in_item  (opcode, row, col, value)
//  out_     | out_strobe, 1 cycle  | out_item (row, col, dot, index error)
//  cfg_     | cfg_valid & cfg_ready| cfg_index, cfg_data (5-bit sizes)
//
//  a load keeps busy low and the next beat may follow at once
//  a compute keeps busy high while it reads min(inner_len, 16) element
//  pairs, one pair per cycle from the two store ports, then passes the
//  pipeline registers (read data, product register) and a result state;
//  an out of range request or a zero inner length goes to the result state
//  the result strobe rises on the cycle busy falls; the receiver cannot stall
//  rst_n is synchronous; sizes reset to 4, store contents are not cleared
// ---------------------------------------------------------------------------
module matrix_element_dot_product (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  mmdp_pkg::in_item_t                 in_item,
  output logic                               out_strobe,
  output mmdp_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mmdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmdp_pkg::CFG_W-1:0]         cfg_data
);
  import mmdp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // size registers are always writable
  assign cfg_ready = 1'b1;

  mmdp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_item.opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  mmdp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== sim/tb_matrix_element_dot_product.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matrix_element_dot_product
// self-checking bench for the integer matrix multiply engine
// ---------------------------------------------------------------------------
// both element stores are filled completely at full size first, so no later
// compute can read an entry that was never written. then a directed run
// covers value extremes, accumulator wrap, zero and oversized sizes, out of
// range loads and computes, the unused opcode and randomly the spare register
// index. random phases follow, each with fresh sizes and its own sender idle
// rate. a scoreboard keeps its own copy of the stores and sizes, predicts
// every result element and compares it field by field with the strobed beat.
// ---------------------------------------------------------------------------
module tb_matrix_element_dot_product;
  import mmdp_pkg::*;

  localparam logic [OPC_W-1:0]     OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 4000;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_BEATS   = 72;

  // scoreboard: mirrored stores and sizes, queue of expected result elements
  class dot_product_tracker;
    logic signed [15:0] first_elems [MAX_DIM][MAX_DIM];
    logic signed [15:0] second_elems [MAX_DIM][MAX_DIM];
    logic [CFG_W-1:0]   size_reg [3];
    out_item_t          pending_dots [$];
    int                 mismatches;

    function new();
      size_reg[CFG_NUM_ROWS]  = CFG_RESET_DIM;
      size_reg[CFG_INNER_LEN] = CFG_RESET_DIM;
      size_reg[CFG_NUM_COLS]  = CFG_RESET_DIM;
      mismatches = 0;
    endfunction

    // size register limited to the store size
    function int unsigned dim(logic [CFG_IDX_W-1:0] idx);
      return (size_reg[idx] > MAX_DIM) ? MAX_DIM : size_reg[idx];
    endfunction

    function void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_NUM_ROWS, CFG_INNER_LEN, CFG_NUM_COLS: size_reg[idx] = data;
        default: ;
      endcase
    endfunction

    // update stores on loads, queue the expected element on computes
    function void note_beat(in_item_t b);
      out_item_t want;
      logic signed [31:0] acc, pa, pb;
      int unsigned rows, inner, cols;
      rows  = dim(CFG_NUM_ROWS);
      inner = dim(CFG_INNER_LEN);
      cols  = dim(CFG_NUM_COLS);
      case (b.opcode)
        OP_LOAD_A:
          if (b.row_index < rows && b.col_index < inner)
            first_elems[b.row_index][b.col_index] = b.elem_value;
        OP_LOAD_B:
          if (b.row_index < inner && b.col_index < cols)
            second_elems[b.row_index][b.col_index] = b.elem_value;
        OP_COMPUTE: begin
          acc = '0;
          want.index_error = (b.row_index >= rows) || (b.col_index >= cols);
          if (!want.index_error) begin
            for (int i = 0; i < inner; i++) begin
              pa  = first_elems[b.row_index][i];
              pb  = second_elems[i][b.col_index];
              acc = acc + pa * pb;
            end
          end
          want.out_row   = b.row_index;
          want.out_col   = b.col_index;
          want.dot_value = acc;
          pending_dots.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void mismatch(string field, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_dots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: row %0d col %0d dot %0d err %0b",
                   got.out_row, got.out_col, got.dot_value, got.index_error);
        return;
      end
      want = pending_dots.pop_front();
      if (got.out_row !== want.out_row)
        mismatch("out_row", want.out_row, got.out_row);
      if (got.out_col !== want.out_col)
        mismatch("out_col", want.out_col, got.out_col);
      if (got.dot_value !== want.dot_value)
        mismatch("dot_value", want.dot_value, got.dot_value);
      if (got.index_error !== want.index_error)
        mismatch("index_error", want.index_error, got.index_error);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  dot_product_tracker tracker = new();
  int idle_pct;
  int stall_cycles;

  matrix_element_dot_product dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      tracker.check_result(out_item);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // one input beat, with random sender idle cycles ahead of it
  task automatic send_beat(in_item_t b);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start   = 1'b1;
    in_item = b;
    do @(posedge clk); while (busy);
    tracker.note_beat(b);
  endtask

  task automatic push(logic [OPC_W-1:0] op, logic [3:0] r, logic [3:0] c,
                      logic signed [15:0] v);
    in_item_t b;
    b.opcode     = op;
    b.row_index  = r;
    b.col_index  = c;
    b.elem_value = v;
    send_beat(b);
  endtask

  // hold the sender until every expected element has arrived
  task automatic wait_results_done();
    @(negedge clk);
    start = 1'b0;
    while (tracker.pending_dots.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_size(idx, data);
  endtask

  // sizes change only with the engine idle and nothing outstanding
  task automatic set_sizes(logic [CFG_W-1:0] r, logic [CFG_W-1:0] i,
                           logic [CFG_W-1:0] c);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(CFG_NUM_ROWS, r);
    cfg_write(CFG_INNER_LEN, i);
    cfg_write(CFG_NUM_COLS, c);
    if ($urandom_range(3) == 0)
      cfg_write(CFG_SPARE, CFG_W'($urandom));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int k;
    k = $urandom_range(99);
    if (k < 20) return CFG_W'(MAX_DIM);
    if (k < 30) return CFG_W'(1);
    if (k < 35) return '0;
    if (k < 40) return CFG_W'($urandom_range(31, MAX_DIM + 1));
    return CFG_W'($urandom_range(MAX_DIM, 1));
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(39))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly in-range loads and computes, some stray indexes and unused opcodes
  function automatic in_item_t random_beat();
    in_item_t b;
    int k;
    int unsigned lr, lc;
    k = $urandom_range(99);
    b.row_index  = 4'($urandom_range(15));
    b.col_index  = 4'($urandom_range(15));
    b.elem_value = pick_value();
    if (k < 45) begin
      b.opcode = $urandom_range(1) ? OP_LOAD_B : OP_LOAD_A;
      lr = (b.opcode == OP_LOAD_A) ? tracker.dim(CFG_NUM_ROWS) : tracker.dim(CFG_INNER_LEN);
      lc = (b.opcode == OP_LOAD_A) ? tracker.dim(CFG_INNER_LEN) : tracker.dim(CFG_NUM_COLS);
    end else if (k < 93) begin
      b.opcode = OP_COMPUTE;
      lr = tracker.dim(CFG_NUM_ROWS);
      lc = tracker.dim(CFG_NUM_COLS);
    end else begin
      b.opcode = OP_UNUSED;
      lr = 0;
      lc = 0;
    end
    if (lr > 0 && lc > 0 && $urandom_range(99) < 85) begin
      b.row_index = 4'($urandom_range(lr - 1));
      b.col_index = 4'($urandom_range(lc - 1));
    end
    return b;
  endfunction

  // stimulus
  initial begin
    int pct_table [3];
    pct_table = '{0, 53, 33};
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill both stores at full size; row 0 / column 0 at the negative
    // extreme and row 15 / column 15 at the positive one, to force wrap
    set_sizes(CFG_W'(MAX_DIM), CFG_W'(MAX_DIM), CFG_W'(MAX_DIM));
    for (int r = 0; r < MAX_DIM; r++)
      for (int c = 0; c < MAX_DIM; c++)
        push(OP_LOAD_A, 4'(r), 4'(c),
             (r == 0) ? 16'h8000 : (r == MAX_DIM - 1) ? 16'h7fff : 16'($urandom));
    for (int r = 0; r < MAX_DIM; r++)
      for (int c = 0; c < MAX_DIM; c++)
        push(OP_LOAD_B, 4'(r), 4'(c),
             (c == 0) ? 16'h8000 : (c == MAX_DIM - 1) ? 16'h7fff : 16'($urandom));

    // corners of the result, accumulator wrap
    push(OP_COMPUTE, 4'd0, 4'd0, 16'h0000);
    push(OP_COMPUTE, 4'd15, 4'd15, 16'hffff);
    push(OP_COMPUTE, 4'd0, 4'd15, 16'h0000);
    push(OP_COMPUTE, 4'd15, 4'd0, 16'h0000);
    // unused opcode gives nothing
    push(OP_UNUSED, 4'd15, 4'd15, 16'hffff);
    push(OP_LOAD_A, 4'd3, 4'd5, 16'h7fff);
    push(OP_LOAD_B, 4'd5, 4'd2, 16'h8000);
    push(OP_COMPUTE, 4'd3, 4'd2, 16'h0000);

    // sizes beyond the store, inner length zero
    set_sizes(5'd31, 5'd0, 5'd17);
    push(OP_COMPUTE, 4'd15, 4'd15, 16'h0000);
    push(OP_LOAD_A, 4'd2, 4'd0, 16'h1234);
    push(OP_COMPUTE, 4'd2, 4'd3, 16'h0000);

    // zero rows: loads to the first matrix ignored, computes flagged
    set_sizes(5'd0, 5'd31, 5'd1);
    push(OP_LOAD_A, 4'd0, 4'd0, 16'h0001);
    push(OP_LOAD_B, 4'd0, 4'd0, 16'h0005);
    push(OP_COMPUTE, 4'd0, 4'd0, 16'h0000);

    // zero columns
    set_sizes(5'd1, 5'd1, 5'd0);
    push(OP_LOAD_B, 4'd0, 4'd0, 16'h0007);
    push(OP_COMPUTE, 4'd0, 4'd0, 16'h0000);

    // smallest sizes, loads and computes just out of range, then one in-range compute
    set_sizes(5'd1, 5'd1, 5'd1);
    push(OP_LOAD_A, 4'd0, 4'd1, 16'h0009);
    push(OP_LOAD_A, 4'd1, 4'd0, 16'h0009);
    push(OP_LOAD_B, 4'd1, 4'd0, 16'h0009);
    push(OP_COMPUTE, 4'd1, 4'd0, 16'h0000);
    push(OP_COMPUTE, 4'd0, 4'd1, 16'h0000);
    push(OP_COMPUTE, 4'd0, 4'd0, 16'h0000);

    // random phases with fresh sizes and sender idle rates
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_sizes(pick_size(), pick_size(), pick_size());
      idle_pct = pct_table[p % 3];
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(99) == 0)
          wait_results_done();
        send_beat(random_beat());
      end
    end

    // drain and report
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_dots.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mmdp_pkg.sv
hdl/mmdp_ram.sv
hdl/mmdp_dp.sv
hdl/mmdp_ctrl.sv
hdl/matrix_element_dot_product.sv
sim/tb_matrix_element_dot_product.sv
